// File: rtl/core/kth_smallest_extract_multiset_defines.svh
// Assertion macros shared by the multiset RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef KTH_SMALLEST_EXTRACT_MULTISET_DEFINES_SVH
`define KTH_SMALLEST_EXTRACT_MULTISET_DEFINES_SVH

`ifndef SYNTHESIS
// Property that holds at every clock edge outside reset.
`define KSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kse assertion failed");
// Condition in one cycle implies consequence in the next.
`define KSE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("kse assertion failed");
`else
`define KSE_ASSERT(lbl, prop)
`define KSE_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: rtl/core/kse_pkg.sv
// Shared types and codes for the k-th smallest multiset block.
// No dependencies.
package kse_pkg;

  localparam int unsigned RankW  = 7;
  localparam int unsigned ValueW = 32;

  // Input command codes.
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // Classified operation; the code doubles as the result status.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_FULL    = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_MISS    = 2'd3
  } kse_op_e;

  typedef struct packed {
    kse_op_e                  op;
    logic signed [ValueW-1:0] value;
  } kse_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_APPLY
  } kse_state_e;

endpackage

// File: rtl/core/kth_smallest_extract_multiset.sv
// Top level of the sorted multiset with k-th smallest extraction.
// Depends on kse_pkg, kse_front, kse_queue and kse_back.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid_i/tready_o      tuser: command, tdata: value
//   m_axis    out        m_axis_tvalid_o/tready_i      tuser: status, tdata: result_value
//   cfg       in         cfg_we_i (no wait)            cfg_wdata_i: rank_k
//
// Each item goes through the back end as a select step, then a shift step,
// and the back end takes no new item before it is through with the last; the
// cell row's compare and shift set its pace. An accepted item passes through
// the queue and both back-end steps before its result is registered. Reset
// clears the fill count, rank_k to one and all handshake state; the cells hold
// no data until written. A stalled result holds in the output register while
// the back end keeps one more item and the queue takes up to two more.
module kth_smallest_extract_multiset #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] value
  input  logic [0:0]  s_axis_tuser_i,  // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] result_value
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);
  import kse_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Front to queue.
  logic            push, q_full;
  kse_cmd_t        push_cmd;
  logic [CntW-1:0] push_idx;
  // Queue to back.
  logic            q_valid, pop;
  kse_cmd_t        q_cmd;
  logic [CntW-1:0] q_idx;
  logic signed [ValueW-1:0] out_value;

  // Classify each transaction against the running count and rank_k.
  kse_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tuser_i[0]),
    .in_value_i ($signed(s_axis_tdata_i)),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .push_idx_o (push_idx)
  );

  // Hold classified work so the front keeps taking items while the back
  // end shifts or waits on the output.
  kse_queue #(.IdxW(CntW)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .push_idx_i (push_idx),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd),
    .idx_o      (q_idx)
  );

  // Apply each operation to the cell row and register its result.
  kse_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .q_idx_i      (q_idx),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_value_o  (out_value)
  );

  assign m_axis_tdata_o = out_value;

endmodule

// File: rtl/core/kse_front.sv
// Front end: accepts items, tracks the fill count and classifies each item.
// Depends on kse_pkg.
module kse_front #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kse_pkg::RankW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_cmd_i,
  input  logic signed [kse_pkg::ValueW-1:0] in_value_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output kse_pkg::kse_cmd_t          push_cmd_o,
  output logic [CntW-1:0]            push_idx_o
);
  import kse_pkg::*;

  localparam int unsigned CmpW = (CntW > RankW) ? CntW : RankW;

  logic [RankW-1:0] rank_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CmpW-1:0]  rank_ext, cnt_ext;
  logic             accept;
  kse_op_e          op;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;
  assign rank_ext   = CmpW'(rank_q);
  assign cnt_ext    = CmpW'(count_q);

  // Classify against the count the back end will see when it runs this item.
  always_comb begin
    if (in_cmd_i == CMD_INSERT) begin
      op         = (count_q == CntW'(CAPACITY)) ? OP_FULL : OP_INSERT;
      push_idx_o = count_q;
    end else begin
      op         = (rank_q == '0 || rank_ext > cnt_ext) ? OP_MISS : OP_EXTRACT;
      push_idx_o = CntW'(rank_ext - CmpW'(1));
    end
  end

  assign push_o           = accept;
  assign push_cmd_o.op    = op;
  assign push_cmd_o.value = in_value_i;

  always_comb begin
    count_d = count_q;
    if (accept && op == OP_INSERT) begin
      count_d = count_q + CntW'(1);
    end else if (accept && op == OP_EXTRACT) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= RankW'(1);
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: rtl/core/kse_queue.sv
// Two-entry queue holding classified operations between front and back.
// Depends on kse_pkg.
module kse_queue #(
  parameter int unsigned IdxW = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kse_pkg::kse_cmd_t push_cmd_i,
  input  logic [IdxW-1:0]   push_idx_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output kse_pkg::kse_cmd_t cmd_o,
  output logic [IdxW-1:0]   idx_o
);
  import kse_pkg::*;

  kse_cmd_t        cmd_q [2];
  logic [IdxW-1:0] idx_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      fill_q;
  logic            do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = cmd_q[rd_ptr_q];
  assign idx_o   = idx_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q] <= push_cmd_i;
      idx_q[wr_ptr_q] <= push_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/kse_back.sv
// Back end: row of sorted cells with parallel compare-and-shift, and the
// registered result stage. Depends on kse_pkg and the assertion macros.
`include "kth_smallest_extract_multiset_defines.svh"

module kse_back #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  kse_pkg::kse_cmd_t          q_cmd_i,
  input  logic [CntW-1:0]            q_idx_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 out_status_o,
  output logic signed [kse_pkg::ValueW-1:0] out_value_o
);
  import kse_pkg::*;

  kse_state_e               state_q, state_d;
  kse_cmd_t                 cur_q;
  logic [CntW-1:0]          idx_q;
  logic [CAPACITY-1:0]      sel_q, sel_d, hit;
  logic signed [ValueW-1:0] cells_q [CAPACITY];
  logic signed [ValueW-1:0] pick;
  logic                     out_vld_q;
  logic [1:0]               out_status_q;
  logic signed [ValueW-1:0] out_value_q;
  logic                     slot_free, done, pop;

  assign slot_free = !out_vld_q || out_ready_i;

  // Outputs of the sequencer.
  always_comb begin
    done = (state_q == ST_APPLY) && slot_free;
    pop  = q_valid_i && ((state_q == ST_IDLE) || done);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  state_d = q_valid_i ? ST_PREP : ST_IDLE;
      ST_PREP:  state_d = ST_APPLY;
      ST_APPLY: begin
        if (done) state_d = q_valid_i ? ST_PREP : ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  assign pop_o = pop;

  // Per-cell select: at or above the target slot, or larger than the new key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_sel
    always_comb begin
      sel_d[i] = (CntW'(i) >= idx_q) ||
                 ((cur_q.op == OP_INSERT) && (cells_q[i] > cur_q.value));
    end
    if (i == 0) begin : g_hit0
      assign hit[i] = sel_q[i];
    end else begin : g_hitn
      assign hit[i] = sel_q[i] && !sel_q[i-1];
    end
  end

  // Shift the cells: up from the insert point, down onto the removed slot.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (done && sel_q[i]) begin
        if (cur_q.op == OP_INSERT) begin
          if (i == 0) begin
            cells_q[i] <= cur_q.value;
          end else begin
            cells_q[i] <= sel_q[(i == 0) ? 0 : i-1] ? cells_q[(i == 0) ? 0 : i-1]
                                                    : cur_q.value;
          end
        end else if (cur_q.op == OP_EXTRACT && i < CAPACITY - 1) begin
          cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i+1 : i];
        end
      end
    end
  end

  always_comb begin
    pick = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) pick = pick | cells_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_cmd_i;
      idx_q <= q_idx_i;
    end
    if (done) begin
      out_status_q <= 2'(cur_q.op);
      out_value_q  <= (cur_q.op == OP_EXTRACT) ? pick : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sel_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PREP) sel_q <= sel_d;
      if (slot_free) out_vld_q <= done;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;

  `KSE_ASSERT(a_sel_thermo, (state_q == ST_APPLY) |-> ((sel_q[CAPACITY-2:0] & ~sel_q[CAPACITY-1:1]) == '0))
  `KSE_ASSERT(a_extract_onehot, (state_q == ST_APPLY && cur_q.op == OP_EXTRACT) |-> $onehot(hit))
  `KSE_ASSERT(a_out_from_apply, $rose(out_vld_q) |-> $past(state_q == ST_APPLY))
  `KSE_ASSERT_NEXT(a_pop_prep, pop, state_q == ST_PREP)

endmodule

// File: tb/tb_kth_smallest_extract_multiset.sv
// Self-checking testbench for kth_smallest_extract_multiset: drives insert and
// extract transactions, predicts each status result and compares it field by field.
// Depends on kse_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_kth_smallest_extract_multiset;
  import kse_pkg::*;

  localparam int unsigned CAPACITY      = 64;
  localparam int unsigned DRAIN_WAIT    = 8;     // margin after the last result
  localparam int unsigned STALL_LIMIT   = 4000;  // cycles without any transaction
  localparam int unsigned PHASE_ITEMS   = 35;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    kse_op_e                  status;
    logic signed [ValueW-1:0] value;
  } status_beat_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [RankW-1:0] cfg_wdata = '0;
  logic             s_tvalid  = 1'b0;
  logic [31:0]      s_tdata   = '0;  // [31:0] value
  logic [0:0]       s_tuser   = '0;  // [0] command
  logic             m_tready  = 1'b0;
  logic             s_tready;
  logic             m_tvalid;
  logic [31:0]      m_tdata;         // [31:0] result_value
  logic [1:0]       m_tuser;         // [1:0] status

  // Shadow copy of the multiset and of rank_k.
  logic signed [ValueW-1:0] ms_vals [CAPACITY];
  int unsigned              ms_count = 0;
  logic [RankW-1:0]         rank_q   = RankW'(1);

  status_beat_t pending_q [$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  item_cnt     = 0;
  int unsigned  rank_writes  = 0;
  int unsigned  status_cnt [4] = '{0, 0, 0, 0};
  bit           no_idle      = 1'b0;

  kth_smallest_extract_multiset #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sorted insert after equal copies, or rank-th extract with shift down.
  function automatic status_beat_t sorted_multiset_step(logic cmd, logic signed [31:0] val);
    status_beat_t r;
    int unsigned  pos;
    r.status = OP_INSERT;
    r.value  = '0;
    if (cmd == CMD_INSERT) begin
      if (ms_count >= CAPACITY) begin
        r.status = OP_FULL;
      end else begin
        pos = ms_count;
        while (pos > 0 && ms_vals[pos-1] > val) begin
          ms_vals[pos] = ms_vals[pos-1];
          pos--;
        end
        ms_vals[pos] = val;
        ms_count++;
      end
    end else if (rank_q == 0 || rank_q > ms_count) begin
      r.status = OP_MISS;
    end else begin
      r.status = OP_EXTRACT;
      r.value  = ms_vals[rank_q-1];
      for (pos = rank_q - 1; pos + 1 < ms_count; pos++) ms_vals[pos] = ms_vals[pos+1];
      ms_count--;
    end
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Full range, small values that collide, and values at or near the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return $urandom_range(0, 16) - 8;
      7:          return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default:    return {($urandom_range(0, 1) ? 8'h80 : 8'h7F), 24'($urandom_range(0, 3))};
    endcase
  endfunction

  // Keep the fill level near the rank so most extracts hit.
  function automatic logic choose_cmd();
    int unsigned pct;
    if (rank_q == 0 || rank_q > CAPACITY) pct = 50;
    else if (ms_count >= CAPACITY)        pct = 15;
    else if (ms_count < rank_q)           pct = 75;
    else                                  pct = 40;
    return ($urandom_range(0, 99) < pct) ? CMD_INSERT : CMD_EXTRACT;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Present one item, hold it until the transaction completes, then predict.
  task automatic send_item(input logic cmd, input logic [31:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= val;
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
    pending_q.insert(pending_q.size(), sorted_multiset_step(cmd, val));
    item_cnt++;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline drain.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_rank(input logic [RankW-1:0] k);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk_i);
    rank_q = k;
    cfg_we <= 1'b0;
    rank_writes++;
  endtask

  task automatic test_directed_edges();
    // rank_k still holds its reset value of one
    send_item(CMD_EXTRACT, 32'hFFFF_FFFF);   // empty store: not found
    send_item(CMD_INSERT,  32'h8000_0000);
    send_item(CMD_INSERT,  32'h7FFF_FFFF);
    send_item(CMD_INSERT,  32'h0000_0000);
    send_item(CMD_INSERT,  32'hFFFF_FFFF);
    send_item(CMD_INSERT,  32'h0000_0001);
    send_item(CMD_INSERT,  32'h0000_0000);   // equal copies
    send_item(CMD_INSERT,  32'h7FFF_FFFF);
    repeat (4) send_item(CMD_EXTRACT, $urandom());  // min, -1, 0, 0
    set_rank(RankW'(0));                     // rank zero names no element
    send_item(CMD_EXTRACT, $urandom());
    set_rank(RankW'(127));                   // rank above capacity
    send_item(CMD_EXTRACT, $urandom());
    set_rank(RankW'(5));                     // rank beyond the three stored
    send_item(CMD_EXTRACT, $urandom());
    set_rank(RankW'(3));
    send_item(CMD_EXTRACT, $urandom());
    set_rank(RankW'(2));
    send_item(CMD_EXTRACT, $urandom());
    set_rank(RankW'(1));
    send_item(CMD_EXTRACT, $urandom());
    send_item(CMD_EXTRACT, $urandom());      // empty again
  endtask

  task automatic test_fill_to_capacity();
    set_rank(RankW'(CAPACITY));
    while (ms_count < CAPACITY) send_item(CMD_INSERT, pick_value());
    repeat (3) send_item(CMD_INSERT, pick_value());   // full store: dropped
    send_item(CMD_EXTRACT, $urandom());              // largest entry
    send_item(CMD_INSERT, 32'h7FFF_FFFF);
    send_item(CMD_INSERT, $urandom());
    set_rank(RankW'(CAPACITY + 1));
    send_item(CMD_EXTRACT, $urandom());
    set_rank(RankW'(1));
    while (ms_count > 0) send_item(CMD_EXTRACT, $urandom());
    send_item(CMD_EXTRACT, $urandom());
  endtask

  task automatic test_random_ranks();
    logic [RankW-1:0] ranks [12] = '{1, 2, 5, 17, 33, 63, 64, 65, 100, 127, 0, 9};
    ranks[11] = RankW'($urandom_range(1, CAPACITY));
    for (int p = 0; p < 12; p++) begin
      set_rank(ranks[p]);
      no_idle = (p % 4 == 3);
      repeat (PHASE_ITEMS) send_item(choose_cmd(), pick_value());
      no_idle = 1'b0;
    end
  endtask

  // Receiver: random back-pressure with the same gap profile.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!rst_ni || no_idle || $urandom_range(0, 99) < 65) begin
      m_tready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      m_tready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    status_beat_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: status %0d value %0d",
                                m_tuser, $signed(m_tdata)));
      end else begin
        want = pending_q.pop_front();
        status_cnt[want.status]++;
        if (m_tuser !== want.status)
          note_mismatch($sformatf("status expected %0d got %0d", want.status, m_tuser));
        if (m_tdata !== want.value)
          note_mismatch($sformatf("result_value expected %0d got %0d",
                                  want.value, $signed(m_tdata)));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[%0t] Watchdog: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_fill_to_capacity();
    test_random_ranks();
    settle();
    $display("Run covered %0d items over %0d rank writes: %0d inserted, %0d dropped full,",
             item_cnt, rank_writes, status_cnt[OP_INSERT], status_cnt[OP_FULL]);
    $display("  %0d extracted, %0d not found; %0d mismatches counted",
             status_cnt[OP_EXTRACT], status_cnt[OP_MISS], mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
